FILE: design/i2cm_pkg.sv
// Package for the I2C master bit engine: phase codes, command kinds,
// engine state, item and result structs. No dependencies.
`default_nettype none

package i2cm_pkg;

	// Command kinds carried by an input word
	localparam logic [2:0] KIND_TICK    = 3'd0;
	localparam logic [2:0] KIND_START   = 3'd1;
	localparam logic [2:0] KIND_RESTART = 3'd2;
	localparam logic [2:0] KIND_STOP    = 3'd3;
	localparam logic [2:0] KIND_WRITE   = 3'd4;
	localparam logic [2:0] KIND_READ    = 3'd5;

	// Configuration register indexes
	localparam logic CFG_HALF_PERIOD = 1'b0;
	localparam logic CFG_ACK_POLL    = 1'b1;

	localparam logic [15:0] HALF_PERIOD_RESET = 16'd5;
	localparam logic [15:0] ACK_POLL_RESET    = 16'd5;
	localparam logic [3:0]  BITS_PER_BYTE     = 4'd8;

	typedef enum logic [4:0] {
		PH_IDLE     = 5'd0,
		PH_ST_A     = 5'd1,
		PH_ST_B     = 5'd2,
		PH_RS_A     = 5'd3,
		PH_RS_B     = 5'd4,
		PH_RS_C     = 5'd5,
		PH_RS_D     = 5'd6,
		PH_SP_A     = 5'd7,
		PH_SP_B     = 5'd8,
		PH_WR_SET   = 5'd9,
		PH_WR_HIGH  = 5'd10,
		PH_WR_LOW   = 5'd11,
		PH_WA_REL   = 5'd12,
		PH_WA_HIGH  = 5'd13,
		PH_WA_POLL  = 5'd14,
		PH_WA_END   = 5'd15,
		PH_RD_HIGH  = 5'd16,
		PH_RD_LOW   = 5'd17,
		PH_RDA_HIGH = 5'd18,
		PH_RDA_LOW  = 5'd19
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] hold_count;
		logic [3:0]  bit_index;
		logic [7:0]  shift_byte;
		logic [15:0] poll_count;
		logic        answer_nack;
		logic        scl;
		logic        sda;
		logic        last_ack;
	} eng_state_t;

	typedef struct packed {
		logic [15:0] half_period;
		logic [15:0] ack_poll_limit;
	} cfg_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       sda_in;
		logic [7:0] tx_byte;
		logic       send_nack;
	} cmd_item_t;

	typedef struct packed {
		logic       scl_level;
		logic       sda_level;
		logic       busy_res;
		logic       done_res;
		logic [7:0] rx_byte;
		logic       ack_nack;
		logic       refused;
	} res_item_t;

endpackage

`default_nettype wire

FILE: design/i2cm_cmd_if.sv
// Command channel: valid/ready handshake plus one input word.
// No dependencies.
`default_nettype none

interface i2cm_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] kind;
	logic       sda_in;
	logic [7:0] tx_byte;
	logic       send_nack;

	modport source (output valid, kind, sda_in, tx_byte, send_nack, input ready);
	modport sink   (input valid, kind, sda_in, tx_byte, send_nack, output ready);
endinterface

`default_nettype wire

FILE: design/i2cm_res_if.sv
// Result channel: valid/ready handshake plus one result word.
// No dependencies.
`default_nettype none

interface i2cm_res_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       busy_res;
	logic       done_res;
	logic [7:0] rx_byte;
	logic       ack_nack;
	logic       refused;

	modport source (output valid, scl_level, sda_level, busy_res, done_res, rx_byte,
		ack_nack, refused, input ready);
	modport sink   (input valid, scl_level, sda_level, busy_res, done_res, rx_byte,
		ack_nack, refused, output ready);
endinterface

`default_nettype wire

FILE: design/i2cm_step.sv
// One engine update: next bus phase, counters and drive levels for one word,
// plus the result word. Depends on i2cm_pkg.
`default_nettype none

module i2cm_step (
	input  wire i2cm_pkg::eng_state_t st,
	input  wire i2cm_pkg::cfg_t       cfg,
	input  wire i2cm_pkg::cmd_item_t  item,
	output i2cm_pkg::eng_state_t      nxt,
	output i2cm_pkg::res_item_t       res
);
	import i2cm_pkg::*;

	logic        is_cmd;
	logic        busy;
	logic        expire;
	logic [15:0] hold_load;
	logic [15:0] poll_lim;
	logic [15:0] poll_inc;
	logic [3:0]  bit_inc;

	assign is_cmd    = (item.kind >= KIND_START) && (item.kind <= KIND_READ);
	assign busy      = (st.phase != PH_IDLE);
	assign expire    = !is_cmd && busy && (st.hold_count <= 16'd1);
	assign hold_load = (cfg.half_period == 16'd0) ? 16'd1 : cfg.half_period;
	assign poll_lim  = (cfg.ack_poll_limit == 16'd0) ? 16'd1 : cfg.ack_poll_limit;
	assign poll_inc  = st.poll_count + 16'd1;
	assign bit_inc   = st.bit_index + 4'd1;

	// Next state
	always_comb begin
		nxt = st;
		if (is_cmd) begin
			if (!busy) begin
				nxt.hold_count = hold_load;
				unique case (item.kind)
					KIND_START: begin
						nxt.sda   = 1'b1;
						nxt.scl   = 1'b1;
						nxt.phase = PH_ST_A;
					end
					KIND_RESTART: begin
						nxt.sda   = 1'b1;
						nxt.phase = PH_RS_A;
					end
					KIND_STOP: begin
						nxt.sda   = 1'b0;
						nxt.scl   = 1'b1;
						nxt.phase = PH_SP_A;
					end
					KIND_WRITE: begin
						nxt.scl        = 1'b0;
						nxt.sda        = item.tx_byte[7];
						nxt.shift_byte = {item.tx_byte[6:0], 1'b0};
						nxt.bit_index  = 4'd0;
						nxt.phase      = PH_WR_SET;
					end
					default: begin
						// read byte
						nxt.sda         = 1'b1;
						nxt.scl         = 1'b1;
						nxt.shift_byte  = 8'd0;
						nxt.bit_index   = 4'd0;
						nxt.answer_nack = item.send_nack;
						nxt.phase       = PH_RD_HIGH;
					end
				endcase
			end
		end else if (busy) begin
			if (!expire) begin
				nxt.hold_count = st.hold_count - 16'd1;
			end else begin
				nxt.hold_count = hold_load;
				unique case (st.phase)
					PH_ST_A: begin nxt.sda = 1'b0; nxt.phase = PH_ST_B; end
					PH_RS_A: begin nxt.scl = 1'b1; nxt.phase = PH_RS_B; end
					PH_RS_B: begin nxt.sda = 1'b0; nxt.phase = PH_RS_C; end
					PH_RS_C: begin nxt.scl = 1'b0; nxt.phase = PH_RS_D; end
					PH_SP_A: begin nxt.sda = 1'b1; nxt.phase = PH_SP_B; end
					PH_WR_SET: begin nxt.scl = 1'b1; nxt.phase = PH_WR_HIGH; end
					PH_WR_HIGH: begin nxt.scl = 1'b0; nxt.phase = PH_WR_LOW; end
					PH_WR_LOW: begin
						nxt.bit_index = bit_inc;
						if (bit_inc < BITS_PER_BYTE) begin
							nxt.sda        = st.shift_byte[7];
							nxt.shift_byte = {st.shift_byte[6:0], 1'b0};
							nxt.phase      = PH_WR_SET;
						end else begin
							nxt.sda   = 1'b1;
							nxt.phase = PH_WA_REL;
						end
					end
					PH_WA_REL: begin nxt.scl = 1'b1; nxt.phase = PH_WA_HIGH; end
					PH_WA_HIGH, PH_WA_POLL: begin
						// first sample on leaving the high phase, then one per tick
						nxt.poll_count = (st.phase == PH_WA_HIGH) ? 16'd0 : poll_inc;
						if ((st.phase == PH_WA_POLL) && (poll_inc >= poll_lim)) begin
							nxt.last_ack = 1'b1;
							nxt.scl      = 1'b0;
							nxt.phase    = PH_WA_END;
						end else if (!item.sda_in) begin
							nxt.last_ack = 1'b0;
							nxt.scl      = 1'b0;
							nxt.phase    = PH_WA_END;
						end else begin
							nxt.phase      = PH_WA_POLL;
							nxt.hold_count = 16'd1;
						end
					end
					PH_RD_HIGH: begin
						nxt.shift_byte = {st.shift_byte[6:0], item.sda_in};
						nxt.scl        = 1'b0;
						nxt.phase      = PH_RD_LOW;
					end
					PH_RD_LOW: begin
						nxt.bit_index = bit_inc;
						nxt.scl       = 1'b1;
						if (bit_inc < BITS_PER_BYTE) begin
							nxt.phase = PH_RD_HIGH;
						end else begin
							nxt.sda   = st.answer_nack;
							nxt.phase = PH_RDA_HIGH;
						end
					end
					PH_RDA_HIGH: begin nxt.scl = 1'b0; nxt.phase = PH_RDA_LOW; end
					PH_ST_B: begin
						nxt.scl        = 1'b0;
						nxt.phase      = PH_IDLE;
						nxt.hold_count = 16'd0;
					end
					default: begin
						// terminal phases: command finished
						nxt.phase      = PH_IDLE;
						nxt.hold_count = 16'd0;
					end
				endcase
			end
		end
	end

	// Result word
	always_comb begin
		res.scl_level = nxt.scl;
		res.sda_level = nxt.sda;
		res.busy_res  = (nxt.phase != PH_IDLE);
		res.ack_nack  = nxt.last_ack;
		res.refused   = is_cmd && busy;
		res.done_res  = expire && ((st.phase == PH_ST_B) || (st.phase == PH_RS_D) ||
			(st.phase == PH_SP_B) || (st.phase == PH_WA_END) || (st.phase == PH_RDA_LOW));
		res.rx_byte   = (expire && (st.phase == PH_RDA_LOW)) ? st.shift_byte : 8'd0;
	end

endmodule

`default_nettype wire

FILE: design/i2c_master_bit_engine.sv
// I2C master bit engine top level: input register, engine update, result register.
// Depends on i2cm_pkg, i2cm_cmd_if, i2cm_res_if and i2cm_step.
// Path: each accepted word is held in the input register, and its result in the result register.
// Throughput: one word per clock while the result is not stalled; the engine update is one pass of i2cm_step.
// A stalled result holds; input stays ready while the input register can drain.
// Reset: bus released (SCL, SDA high), phase idle, last acknowledge NACK, registers 5.
`default_nettype none

module i2c_master_bit_engine (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_data,
	i2cm_cmd_if.sink         cmd,
	i2cm_res_if.source       res
);
	import i2cm_pkg::*;

	cfg_t       cfg_q;
	eng_state_t state_q;
	eng_state_t state_nxt;
	cmd_item_t  item_s1;
	logic       valid_s1;
	res_item_t  res_s2;
	res_item_t  res_nxt;
	logic       valid_s2;
	logic       stall;
	logic       advance;

	assign stall     = valid_s2 && !res.ready;
	assign advance   = valid_s1 && !stall;
	assign cmd.ready = !valid_s1 || !stall;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.half_period    <= HALF_PERIOD_RESET;
			cfg_q.ack_poll_limit <= ACK_POLL_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_HALF_PERIOD) cfg_q.half_period <= cfg_data;
			if (cfg_index == CFG_ACK_POLL)    cfg_q.ack_poll_limit <= cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			item_s1.kind      <= cmd.kind;
			item_s1.sda_in    <= cmd.sda_in;
			item_s1.tx_byte   <= cmd.tx_byte;
			item_s1.send_nack <= cmd.send_nack;
		end
	end

	i2cm_step u_step (
		.st   (state_q),
		.cfg  (cfg_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Engine state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase       <= PH_IDLE;
			state_q.hold_count  <= 16'd0;
			state_q.bit_index   <= 4'd0;
			state_q.shift_byte  <= 8'd0;
			state_q.poll_count  <= 16'd0;
			state_q.answer_nack <= 1'b0;
			state_q.scl         <= 1'b1;
			state_q.sda         <= 1'b1;
			state_q.last_ack    <= 1'b1;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) res_s2 <= res_nxt;
	end

	assign res.valid     = valid_s2;
	assign res.scl_level = res_s2.scl_level;
	assign res.sda_level = res_s2.sda_level;
	assign res.busy_res  = res_s2.busy_res;
	assign res.done_res  = res_s2.done_res;
	assign res.rx_byte   = res_s2.rx_byte;
	assign res.ack_nack  = res_s2.ack_nack;
	assign res.refused   = res_s2.refused;

	// Checks
	a_idle_no_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q.phase == PH_IDLE) |-> (state_q.hold_count == 16'd0))
		else $error("hold count left over in idle");

	a_bit_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bit_index <= BITS_PER_BYTE)
		else $error("bit index beyond one byte");

	a_refused_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.refused) |-> (res_s2.busy_res && !res_s2.done_res))
		else $error("refusal reported while idle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.done_res) |-> !res_s2.busy_res)
		else $error("done reported with engine still busy");

	a_rx_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && (res_s2.rx_byte != 8'd0)) |-> res_s2.done_res)
		else $error("received byte outside read completion");

endmodule

`default_nettype wire
